@@ rtl/gppci_pkg.sv @@
package gppci_pkg;

    localparam int SIDE_W    = 13;
    localparam int LVL_W     = 4;
    localparam int IDX_W     = 24;
    localparam int PAR_W     = 22;
    localparam int AREA_W    = 2 * SIDE_W;
    localparam int CFG_IDX_W = 1;
    localparam int PROW_W    = SIDE_W - 1;
    localparam int PPROD_W   = PROW_W + SIDE_W;
    localparam int CROW_W    = SIDE_W + 1;
    localparam int CPROD_W   = CROW_W + SIDE_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_ROWS,
        REG_BASE_COLS
    } t_cfg_reg;

    // Item travelling down the division chain: grid dimensions of the level
    // and the level below, plus the partial remainder and the shifting
    // dividend/quotient word.
    typedef struct packed {
        logic [LVL_W-1:0]  lvl;
        logic [SIDE_W-1:0] r;
        logic [SIDE_W-1:0] c;
        logic [SIDE_W-1:0] fr;
        logic [SIDE_W-1:0] fc;
        logic              bad;
        logic [SIDE_W-1:0] rem;
        logic [IDX_W-1:0]  num;
    } t_div;

    typedef struct packed {
        logic [PAR_W-1:0] parent_index;
        logic             parent_ok;
        logic [IDX_W-1:0] child_first;
        logic [IDX_W-1:0] child_right;
        logic [IDX_W-1:0] child_below;
        logic [IDX_W-1:0] child_diag;
        logic             first_ok;
        logic             right_ok;
        logic             below_ok;
        logic             diag_ok;
        logic             index_error;
    } t_res;

    // Side length after s halvings, each rounding up: ceil(v / 2^s).
    function automatic logic [SIDE_W-1:0] ceil_shr(input logic [SIDE_W-1:0] v,
                                                  input logic [LVL_W-1:0]  s);
        logic [SIDE_W-1:0] q;
        logic [SIDE_W-1:0] m;
        q = v >> s;
        m = ~({SIDE_W{1'b1}} << s);
        return q + {{(SIDE_W-1){1'b0}}, |(v & m)};
    endfunction

endpackage

@@ rtl/gppci_in_if.sv @@
interface gppci_in_if;
    logic                           valid;
    logic                           ready;
    logic [gppci_pkg::LVL_W-1:0]    level;
    logic [gppci_pkg::IDX_W-1:0]    node_index;

    modport source (output valid, output level, output node_index, input ready);
    modport sink   (input valid, input level, input node_index, output ready);
endinterface

@@ rtl/gppci_res_if.sv @@
interface gppci_res_if;
    logic                           valid;
    logic                           ready;
    logic [gppci_pkg::PAR_W-1:0]    parent_index;
    logic                           parent_ok;
    logic [gppci_pkg::IDX_W-1:0]    child_first;
    logic [gppci_pkg::IDX_W-1:0]    child_right;
    logic [gppci_pkg::IDX_W-1:0]    child_below;
    logic [gppci_pkg::IDX_W-1:0]    child_diag;
    logic                           first_ok;
    logic                           right_ok;
    logic                           below_ok;
    logic                           diag_ok;
    logic                           index_error;

    modport source (
        output valid, output parent_index, output parent_ok,
        output child_first, output child_right, output child_below, output child_diag,
        output first_ok, output right_ok, output below_ok, output diag_ok,
        output index_error, input ready
    );
    modport sink (
        input valid, input parent_index, input parent_ok,
        input child_first, input child_right, input child_below, input child_diag,
        input first_ok, input right_ok, input below_ok, input diag_ok,
        input index_error, output ready
    );
endinterface

@@ rtl/gppci_front.sv @@
module gppci_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_vld,
    output logic                                o_rdy,
    input  logic [gppci_pkg::LVL_W-1:0]         i_level,
    input  logic [gppci_pkg::IDX_W-1:0]         i_node_index,
    input  logic [gppci_pkg::SIDE_W-1:0]        i_rows,
    input  logic [gppci_pkg::SIDE_W-1:0]        i_cols,
    output logic                                o_vld,
    input  logic                                i_rdy,
    output gppci_pkg::t_div                     o_d
);

    typedef struct packed {
        logic [gppci_pkg::LVL_W-1:0]  lvl;
        logic [gppci_pkg::IDX_W-1:0]  idx;
        logic [gppci_pkg::SIDE_W-1:0] r;
        logic [gppci_pkg::SIDE_W-1:0] c;
        logic [gppci_pkg::SIDE_W-1:0] fr;
        logic [gppci_pkg::SIDE_W-1:0] fc;
        logic                         lvl_bad;
    } t_fstage;

    logic                            r1_vld;
    t_fstage                         r1;
    t_fstage                         n1;
    logic                            r2_vld;
    t_fstage                         r2;
    logic [gppci_pkg::AREA_W-1:0]    r2_area;
    logic                            w_take1;
    logic                            w_take2;
    logic [gppci_pkg::LVL_W-1:0]     w_lvl_m1;

    assign w_take2 = !r2_vld || i_rdy;
    assign w_take1 = !r1_vld || w_take2;
    assign o_rdy   = w_take1;
    assign w_lvl_m1 = i_level - gppci_pkg::LVL_W'(1);

    // The node's level sits above the top when the level below it is
    // already a single node.
    always_comb begin
        n1.lvl     = i_level;
        n1.idx     = i_node_index;
        n1.r       = gppci_pkg::ceil_shr(i_rows, i_level);
        n1.c       = gppci_pkg::ceil_shr(i_cols, i_level);
        n1.fr      = gppci_pkg::ceil_shr(i_rows, w_lvl_m1);
        n1.fc      = gppci_pkg::ceil_shr(i_cols, w_lvl_m1);
        n1.lvl_bad = (i_level != '0) && (n1.fr == gppci_pkg::SIDE_W'(1))
                     && (n1.fc == gppci_pkg::SIDE_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else begin
            if (w_take1) begin
                r1_vld <= i_vld;
            end
            if (w_take2) begin
                r2_vld <= r1_vld;
            end
        end
        if (w_take1 && i_vld) begin
            r1 <= n1;
        end
        if (w_take2 && r1_vld) begin
            r2      <= r1;
            r2_area <= gppci_pkg::AREA_W'(r1.r) * gppci_pkg::AREA_W'(r1.c);
        end
    end

    always_comb begin
        o_d.lvl = r2.lvl;
        o_d.r   = r2.r;
        o_d.c   = r2.c;
        o_d.fr  = r2.fr;
        o_d.fc  = r2.fc;
        o_d.bad = r2.lvl_bad || (gppci_pkg::AREA_W'(r2.idx) >= r2_area);
        o_d.rem = '0;
        o_d.num = r2.idx;
    end

    assign o_vld = r2_vld;

endmodule

@@ rtl/gppci_div_cell.sv @@
module gppci_div_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    output logic            o_rdy,
    input  gppci_pkg::t_div i_d,
    output logic            o_vld,
    input  logic            i_rdy,
    output gppci_pkg::t_div o_d
);

    logic                           r_vld;
    gppci_pkg::t_div                r_d;
    gppci_pkg::t_div                n_d;
    logic [gppci_pkg::SIDE_W:0]     w_trial;
    logic                           w_ge;
    logic                           w_take;

    assign w_take = !r_vld || i_rdy;
    assign o_rdy  = w_take;

    // One restoring step: bring down the next dividend bit and subtract the
    // column count where it fits.
    always_comb begin
        w_trial = {i_d.rem, i_d.num[gppci_pkg::IDX_W-1]};
        w_ge    = w_trial >= {1'b0, i_d.c};
        n_d     = i_d;
        if (w_ge) begin
            n_d.rem = gppci_pkg::SIDE_W'(w_trial - {1'b0, i_d.c});
        end else begin
            n_d.rem = w_trial[gppci_pkg::SIDE_W-1:0];
        end
        n_d.num = {i_d.num[gppci_pkg::IDX_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_take) begin
            r_vld <= i_vld;
        end
        if (w_take && i_vld) begin
            r_d <= n_d;
        end
    end

    assign o_vld = r_vld;
    assign o_d   = r_d;

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |-> (r_d.rem < r_d.c))
        else $error("partial remainder not below column count");

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |-> (r_d.c != '0))
        else $error("zero column count in division chain");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && !i_rdy) |=> (r_vld && $stable(r_d)))
        else $error("stalled item changed in division cell");
`endif

endmodule

@@ rtl/gppci_back.sv @@
module gppci_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    output logic            o_rdy,
    input  gppci_pkg::t_div i_d,
    output logic            o_vld,
    input  logic            i_rdy,
    output gppci_pkg::t_res o_res
);

    typedef struct packed {
        logic                          lvl_nz;
        logic                          bad;
        logic                          parent_ok;
        logic [gppci_pkg::PROW_W-1:0]  col_half;
        logic [gppci_pkg::PPROD_W-1:0] pprod;
        logic [gppci_pkg::CROW_W-1:0]  ccol;
        logic [gppci_pkg::CPROD_W-1:0] cprod;
        logic [gppci_pkg::SIDE_W-1:0]  fc;
        logic                          rok;
        logic                          bok;
    } t_mid;

    logic                            rp_vld;
    t_mid                            rp;
    t_mid                            n_p;
    logic                            ro_vld;
    gppci_pkg::t_res                 ro;
    gppci_pkg::t_res                 n_o;
    logic                            w_takep;
    logic                            w_takeo;
    logic [gppci_pkg::SIDE_W-1:0]    w_row;
    logic [gppci_pkg::SIDE_W-1:0]    w_col;
    logic [gppci_pkg::SIDE_W-1:0]    w_pc;
    logic [gppci_pkg::CROW_W-1:0]    w_crow;
    logic [gppci_pkg::CPROD_W:0]     w_first;
    logic [gppci_pkg::CPROD_W:0]     w_below;
    logic [gppci_pkg::PPROD_W:0]     w_parent;
    logic                            w_pok;
    logic                            w_fok;
    logic                            w_rok;
    logic                            w_bok;

    assign w_takeo = !ro_vld || i_rdy;
    assign w_takep = !rp_vld || w_takeo;
    assign o_rdy   = w_takep;

    // After the chain the quotient is the row and the remainder the column.
    always_comb begin
        w_row  = i_d.num[gppci_pkg::SIDE_W-1:0];
        w_col  = i_d.rem;
        w_pc   = (i_d.c >> 1) + {{(gppci_pkg::SIDE_W-1){1'b0}}, i_d.c[0]};
        w_crow = {w_row, 1'b0};
        n_p.lvl_nz    = i_d.lvl != '0;
        n_p.bad       = i_d.bad;
        n_p.parent_ok = (i_d.r != gppci_pkg::SIDE_W'(1)) || (i_d.c != gppci_pkg::SIDE_W'(1));
        n_p.col_half  = w_col[gppci_pkg::SIDE_W-1:1];
        n_p.pprod     = gppci_pkg::PPROD_W'(w_row[gppci_pkg::SIDE_W-1:1])
                        * gppci_pkg::PPROD_W'(w_pc);
        n_p.ccol      = {w_col, 1'b0};
        n_p.cprod     = gppci_pkg::CPROD_W'(w_crow) * gppci_pkg::CPROD_W'(i_d.fc);
        n_p.fc        = i_d.fc;
        n_p.rok       = ({1'b0, n_p.ccol} + (gppci_pkg::CROW_W+1)'(1))
                        < (gppci_pkg::CROW_W+1)'(i_d.fc);
        n_p.bok       = ({1'b0, w_crow} + (gppci_pkg::CROW_W+1)'(1))
                        < (gppci_pkg::CROW_W+1)'(i_d.fr);
    end

    always_comb begin
        w_pok    = !rp.bad && rp.parent_ok;
        w_fok    = !rp.bad && rp.lvl_nz;
        w_rok    = w_fok && rp.rok;
        w_bok    = w_fok && rp.bok;
        w_parent = (gppci_pkg::PPROD_W+1)'(rp.pprod) + (gppci_pkg::PPROD_W+1)'(rp.col_half);
        w_first  = (gppci_pkg::CPROD_W+1)'(rp.cprod) + (gppci_pkg::CPROD_W+1)'(rp.ccol);
        w_below  = w_first + (gppci_pkg::CPROD_W+1)'(rp.fc);

        n_o              = '0;
        n_o.index_error  = rp.bad;
        n_o.parent_ok    = w_pok;
        n_o.first_ok     = w_fok;
        n_o.right_ok     = w_rok;
        n_o.below_ok     = w_bok;
        n_o.diag_ok      = w_rok && w_bok;
        if (w_pok) begin
            n_o.parent_index = w_parent[gppci_pkg::PAR_W-1:0];
        end
        if (w_fok) begin
            n_o.child_first = w_first[gppci_pkg::IDX_W-1:0];
        end
        if (w_rok) begin
            n_o.child_right = w_first[gppci_pkg::IDX_W-1:0] + gppci_pkg::IDX_W'(1);
        end
        if (w_bok) begin
            n_o.child_below = w_below[gppci_pkg::IDX_W-1:0];
        end
        if (w_rok && w_bok) begin
            n_o.child_diag = w_below[gppci_pkg::IDX_W-1:0] + gppci_pkg::IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rp_vld <= 1'b0;
            ro_vld <= 1'b0;
        end else begin
            if (w_takep) begin
                rp_vld <= i_vld;
            end
            if (w_takeo) begin
                ro_vld <= rp_vld;
            end
        end
        if (w_takep && i_vld) begin
            rp <= n_p;
        end
        if (w_takeo && rp_vld) begin
            ro <= n_o;
        end
    end

    assign o_vld = ro_vld;
    assign o_res = ro;

endmodule

@@ rtl/grid_pyramid_parent_child_index.sv @@
// Parent and child lookup for a quadtree grid pyramid whose finest level is
// base_rows x base_cols (zero reads as one, values above MAX_SIDE saturate).
// Each item gives a level and a row-major node index; the result carries the
// parent index one level up and the four child indices one level down, each
// with its exists flag, or only index_error when the level lies above the
// top or the index lies outside its level's grid. One item is taken every
// clock given a ready sink: the front registers form the level dimensions
// and then the grid area, 24 cells of a restoring divider chain split the
// index into row and column one bit per cell, and the back registers form
// the products and then the sums in the output register. A stalled sink
// fills the chain up before input ready drops. Configuration must be
// written only while no item is in flight; the block does not enforce it.
module grid_pyramid_parent_child_index #(
    parameter int MAX_SIDE = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gppci_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [gppci_pkg::SIDE_W-1:0]        i_cfg_data,
    gppci_in_if.sink                            i_in,
    gppci_res_if.source                         o_res
);

    localparam int NCELL = gppci_pkg::IDX_W;

    logic [gppci_pkg::SIDE_W-1:0]    r_base_rows;
    logic [gppci_pkg::SIDE_W-1:0]    r_base_cols;
    logic [gppci_pkg::SIDE_W-1:0]    w_rows;
    logic [gppci_pkg::SIDE_W-1:0]    w_cols;
    logic                            w_vld [0:NCELL];
    logic                            w_rdy [0:NCELL];
    gppci_pkg::t_div                 w_d   [0:NCELL];
    gppci_pkg::t_res                 w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_rows <= gppci_pkg::SIDE_W'(1);
            r_base_cols <= gppci_pkg::SIDE_W'(1);
        end else if (i_cfg_we) begin
            unique case (gppci_pkg::t_cfg_reg'(i_cfg_idx))
                gppci_pkg::REG_BASE_ROWS: begin
                    r_base_rows <= i_cfg_data;
                end
                gppci_pkg::REG_BASE_COLS: begin
                    r_base_cols <= i_cfg_data;
                end
            endcase
        end
    end

    always_comb begin
        w_rows = r_base_rows;
        if (r_base_rows == '0) begin
            w_rows = gppci_pkg::SIDE_W'(1);
        end else if (32'(r_base_rows) > MAX_SIDE) begin
            w_rows = gppci_pkg::SIDE_W'(MAX_SIDE);
        end
        w_cols = r_base_cols;
        if (r_base_cols == '0) begin
            w_cols = gppci_pkg::SIDE_W'(1);
        end else if (32'(r_base_cols) > MAX_SIDE) begin
            w_cols = gppci_pkg::SIDE_W'(MAX_SIDE);
        end
    end

    gppci_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (i_in.valid),
        .o_rdy        (i_in.ready),
        .i_level      (i_in.level),
        .i_node_index (i_in.node_index),
        .i_rows       (w_rows),
        .i_cols       (w_cols),
        .o_vld        (w_vld[0]),
        .i_rdy        (w_rdy[0]),
        .o_d          (w_d[0])
    );

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        gppci_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_vld[g]),
            .o_rdy   (w_rdy[g]),
            .i_d     (w_d[g]),
            .o_vld   (w_vld[g+1]),
            .i_rdy   (w_rdy[g+1]),
            .o_d     (w_d[g+1])
        );
    end

    gppci_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_vld[NCELL]),
        .o_rdy   (w_rdy[NCELL]),
        .i_d     (w_d[NCELL]),
        .o_vld   (o_res.valid),
        .i_rdy   (o_res.ready),
        .o_res   (w_res)
    );

    assign o_res.parent_index = w_res.parent_index;
    assign o_res.parent_ok    = w_res.parent_ok;
    assign o_res.child_first  = w_res.child_first;
    assign o_res.child_right  = w_res.child_right;
    assign o_res.child_below  = w_res.child_below;
    assign o_res.child_diag   = w_res.child_diag;
    assign o_res.first_ok     = w_res.first_ok;
    assign o_res.right_ok     = w_res.right_ok;
    assign o_res.below_ok     = w_res.below_ok;
    assign o_res.diag_ok      = w_res.diag_ok;
    assign o_res.index_error  = w_res.index_error;

`ifndef SYNTHESIS
    a_full_before_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_res.valid)
        else $error("input blocked while the output register is empty");

    a_empty_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (!o_res.valid && i_in.ready))
        else $error("pipeline not empty after reset");

    a_error_clears_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.index_error) |->
            (!o_res.parent_ok && !o_res.first_ok && !o_res.right_ok
             && !o_res.below_ok && !o_res.diag_ok && o_res.parent_index == '0
             && o_res.child_first == '0))
        else $error("erroneous item carries a parent or child");
`endif

endmodule
